// ===== rtl/core/ptbl_pkg.sv =====
`default_nettype none
package ptbl_pkg;

  localparam int unsigned COORD_BITS_DEF      = 32;
  localparam int unsigned AXIS_BLOCK_BITS_DEF = 12;
  localparam int unsigned DIV_STEP_BITS       = 4;
  localparam int unsigned CFG_IDX_W           = 3;
  localparam int unsigned NUM_AXES            = 3;
  localparam int unsigned SIZE_RST            = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_DEPTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DIMS    = 3'd6;

endpackage
`default_nettype wire

// ===== rtl/core/ptbl_divider.sv =====
`default_nettype none
module ptbl_divider #(
  parameter int unsigned COORD_BITS      = ptbl_pkg::COORD_BITS_DEF,
  parameter int unsigned AXIS_BLOCK_BITS = ptbl_pkg::AXIS_BLOCK_BITS_DEF,
  localparam int unsigned STEP   = ptbl_pkg::DIV_STEP_BITS,
  localparam int unsigned STAGES = (COORD_BITS + STEP - 1) / STEP
) (
  input  wire logic                       clk_i,
  input  wire logic [STAGES-1:0]          en_i,
  input  wire logic [COORD_BITS-1:0]      dividend_i,
  input  wire logic                       neg_i,
  input  wire logic [AXIS_BLOCK_BITS:0]   size_i,
  output logic [COORD_BITS-1:0]           quot_o,
  output logic [AXIS_BLOCK_BITS:0]        rem_o,
  output logic                            neg_o
);

  logic [AXIS_BLOCK_BITS:0]  rem_q  [STAGES];
  logic [COORD_BITS-1:0]     work_q [STAGES];
  logic                      neg_q  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [AXIS_BLOCK_BITS:0] rem_in;
    logic [COORD_BITS-1:0]    work_in;
    logic                     neg_in;
    logic [AXIS_BLOCK_BITS:0] rem_d;
    logic [COORD_BITS-1:0]    work_d;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = dividend_i;
      assign neg_in  = neg_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign work_in = work_q[k-1];
      assign neg_in  = neg_q[k-1];
    end

    // restoring division, a few quotient bits per stage
    always_comb begin
      logic [AXIS_BLOCK_BITS:0]   r;
      logic [COORD_BITS-1:0]      w;
      logic [AXIS_BLOCK_BITS+1:0] t;
      r = rem_in;
      w = work_in;
      t = '0;
      for (int j = 0; j < STEP; j++) begin
        if (k * STEP + j < COORD_BITS) begin
          t = {r, w[COORD_BITS-1]};
          w = {w[COORD_BITS-2:0], 1'b0};
          if (t >= {1'b0, size_i}) begin
            t    = t - {1'b0, size_i};
            w[0] = 1'b1;
          end
          r = t[AXIS_BLOCK_BITS:0];
        end
      end
      rem_d  = r;
      work_d = w;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k]  <= rem_d;
        work_q[k] <= work_d;
        neg_q[k]  <= neg_in;
      end
    end
  end

  assign quot_o = work_q[STAGES-1];
  assign rem_o  = rem_q[STAGES-1];
  assign neg_o  = neg_q[STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/ptbl_linear.sv =====
`default_nettype none
module ptbl_linear #(
  parameter int unsigned AXIS_BLOCK_BITS = ptbl_pkg::AXIS_BLOCK_BITS_DEF,
  localparam int unsigned LIN_W = 3 * AXIS_BLOCK_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic [1:0]                   en_i,
  input  wire logic [LIN_W-1:0]             grid_dims_i,
  input  wire logic [AXIS_BLOCK_BITS-1:0]   bx_i,
  input  wire logic [AXIS_BLOCK_BITS-1:0]   by_i,
  input  wire logic [AXIS_BLOCK_BITS-1:0]   bz_i,
  input  wire logic                         in_grid_i,
  output logic [LIN_W-1:0]                  lin_o
);

  localparam int unsigned AB = AXIS_BLOCK_BITS;

  logic [2*AB-1:0]  wh_q;
  logic [LIN_W-1:0] zwh_q;
  logic [2*AB-1:0]  yw_q;
  logic [AB-1:0]    bx_q;
  logic             in_q;
  logic [LIN_W-1:0] lin_q;

  // plane size, follows configuration
  always_ff @(posedge clk_i) begin
    wh_q <= grid_dims_i[AB-1:0] * grid_dims_i[2*AB-1:AB];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      zwh_q <= bz_i * wh_q;
      yw_q  <= by_i * grid_dims_i[AB-1:0];
      bx_q  <= bx_i;
      in_q  <= in_grid_i;
    end
    if (en_i[1]) begin
      lin_q <= in_q ? (zwh_q + LIN_W'(yw_q) + LIN_W'(bx_q)) : '0;
    end
  end

  assign lin_o = lin_q;

endmodule
`default_nettype wire

// ===== rtl/core/point_to_block_location.sv =====
`default_nettype none
// throughput: one beat per cycle while m_axis_tready is high; each axis has its own divider pipeline
// retiring four quotient bits per stage, a stall holds every occupied stage in place while empty stages still fill
// reset: asynchronous active low, clears valid bits and configuration
// (origins 0, block sizes 32, grid dims 0)
module point_to_block_location #(
  parameter int unsigned COORD_BITS      = ptbl_pkg::COORD_BITS_DEF,
  parameter int unsigned AXIS_BLOCK_BITS = ptbl_pkg::AXIS_BLOCK_BITS_DEF,
  localparam int unsigned CB     = COORD_BITS,
  localparam int unsigned AB     = AXIS_BLOCK_BITS,
  localparam int unsigned IN_W   = ((3 * CB + 7) / 8) * 8,
  localparam int unsigned OUT_RAW = 3 * (CB + 1) + 3 * AB + 1 + 3 * AB,
  localparam int unsigned OUT_W  = ((OUT_RAW + 7) / 8) * 8,
  localparam int unsigned CFG_W0 = (CB > 3 * AB) ? CB : 3 * AB,
  localparam int unsigned CFG_W  = (CFG_W0 > AB + 1) ? CFG_W0 : AB + 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ptbl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_W-1:0]                  cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // point_x, point_y, point_z
  input  wire logic [IN_W-1:0]                   s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // block_x, block_y, block_z, local_x, local_y, local_z, in_grid, linear_index
  output logic [OUT_W-1:0]                       m_axis_tdata
);

  localparam int unsigned NA     = ptbl_pkg::NUM_AXES;
  localparam int unsigned STEP   = ptbl_pkg::DIV_STEP_BITS;
  localparam int unsigned DIV_N  = (CB + STEP - 1) / STEP;
  localparam int unsigned NSTG   = DIV_N + 4;
  localparam int unsigned FIX_S  = DIV_N + 1;

  logic [CB-1:0]     origin_q [NA];
  logic [AB:0]       size_q   [NA];
  logic [3*AB-1:0]   dims_q;
  logic [AB:0]       eff_size [NA];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NA; a++) begin
        origin_q[a] <= '0;
        size_q[a]   <= (AB+1)'(ptbl_pkg::SIZE_RST);
      end
      dims_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ptbl_pkg::CFG_ORIGIN_X:     origin_q[0] <= cfg_data_i[CB-1:0];
        ptbl_pkg::CFG_ORIGIN_Y:     origin_q[1] <= cfg_data_i[CB-1:0];
        ptbl_pkg::CFG_ORIGIN_Z:     origin_q[2] <= cfg_data_i[CB-1:0];
        ptbl_pkg::CFG_BLOCK_WIDTH:  size_q[0]   <= cfg_data_i[AB:0];
        ptbl_pkg::CFG_BLOCK_HEIGHT: size_q[1]   <= cfg_data_i[AB:0];
        ptbl_pkg::CFG_BLOCK_DEPTH:  size_q[2]   <= cfg_data_i[AB:0];
        ptbl_pkg::CFG_GRID_DIMS:    dims_q      <= cfg_data_i[3*AB-1:0];
        default: ;
      endcase
    end
  end

  // zero means one, above 2^AB saturates
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      if (size_q[a] == '0) begin
        eff_size[a] = (AB+1)'(1);
      end else if (size_q[a][AB] && (size_q[a][AB-1:0] != '0)) begin
        eff_size[a] = {1'b1, {AB{1'b0}}};
      end else begin
        eff_size[a] = size_q[a];
      end
    end
  end

  // valid chain and per-stage advance
  logic [NSTG-1:0] valid_q;
  logic [NSTG:0]   en;

  always_comb begin
    en[NSTG] = m_axis_tready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[NSTG-1];

  // stage 0: offset from origin, split into sign and magnitude (magnitude minus one when negative)
  logic [CB-1:0] mag_q [NA];
  logic          neg_q [NA];
  logic [CB-1:0] quot  [NA];
  logic [AB:0]   rem   [NA];
  logic          dneg  [NA];

  for (genvar a = 0; a < NA; a++) begin : g_axis
    logic [CB:0] diff;
    assign diff = {s_axis_tdata[a*CB+CB-1], s_axis_tdata[a*CB +: CB]}
                - {origin_q[a][CB-1], origin_q[a]};

    always_ff @(posedge clk_i) begin
      if (en[0]) begin
        neg_q[a] <= diff[CB];
        mag_q[a] <= diff[CB] ? ~diff[CB-1:0] : diff[CB-1:0];
      end
    end

    ptbl_divider #(
      .COORD_BITS      (CB),
      .AXIS_BLOCK_BITS (AB)
    ) u_div (
      .clk_i      (clk_i),
      .en_i       (en[DIV_N:1]),
      .dividend_i (mag_q[a]),
      .neg_i      (neg_q[a]),
      .size_i     (eff_size[a]),
      .quot_o     (quot[a]),
      .rem_o      (rem[a]),
      .neg_o      (dneg[a])
    );
  end

  // fixup: floor quotient, remainder, grid test
  logic [CB:0]   blk_q   [NA];
  logic [AB-1:0] loc_q   [NA];
  logic          inside_q;
  logic          inside_d;

  always_ff @(posedge clk_i) begin
    if (en[FIX_S]) begin
      for (int a = 0; a < NA; a++) begin
        blk_q[a] <= dneg[a] ? ~{1'b0, quot[a]} : {1'b0, quot[a]};
        loc_q[a] <= dneg[a] ? AB'(eff_size[a] - (AB+1)'(1) - rem[a]) : rem[a][AB-1:0];
      end
      inside_q <= inside_d;
    end
  end

  always_comb begin
    logic [CB+AB:0] qz;
    logic [CB+AB:0] dz;
    inside_d = 1'b1;
    for (int a = 0; a < NA; a++) begin
      qz = (CB+AB+1)'(quot[a]);
      dz = (CB+AB+1)'(dims_q[a*AB +: AB]);
      if (dneg[a] || !(qz < dz)) begin
        inside_d = 1'b0;
      end
    end
  end

  // carry fields through the index multiply stages
  logic [CB:0]   blk1_q [NA];
  logic [AB-1:0] loc1_q [NA];
  logic          in1_q;
  logic [CB:0]   blk2_q [NA];
  logic [AB-1:0] loc2_q [NA];
  logic          in2_q;

  always_ff @(posedge clk_i) begin
    if (en[FIX_S+1]) begin
      blk1_q <= blk_q;
      loc1_q <= loc_q;
      in1_q  <= inside_q;
    end
    if (en[FIX_S+2]) begin
      blk2_q <= blk1_q;
      loc2_q <= loc1_q;
      in2_q  <= in1_q;
    end
  end

  logic [3*AB-1:0] lin;

  ptbl_linear #(
    .AXIS_BLOCK_BITS (AB)
  ) u_linear (
    .clk_i       (clk_i),
    .en_i        (en[FIX_S+2:FIX_S+1]),
    .grid_dims_i (dims_q),
    .bx_i        (blk_q[0][AB-1:0]),
    .by_i        (blk_q[1][AB-1:0]),
    .bz_i        (blk_q[2][AB-1:0]),
    .in_grid_i   (inside_q),
    .lin_o       (lin)
  );

  assign m_axis_tdata = OUT_W'({lin, in2_q, loc2_q[2], loc2_q[1], loc2_q[0],
                                blk2_q[2], blk2_q[1], blk2_q[0]});

endmodule
`default_nettype wire

// ===== test/point_to_block_location_tb.sv =====
`default_nettype none
module point_to_block_location_tb;

  localparam int CB = 32;
  localparam int AB = 12;
  localparam int IN_W = 96;
  localparam int OUT_W = 176;
  localparam int CFG_W = 36;
  localparam int LATENCY = 12;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [3*AB-1:0] linear_index;
    logic            in_grid;
    logic [AB-1:0]   local_z;
    logic [AB-1:0]   local_y;
    logic [AB-1:0]   local_x;
    logic [CB:0]     block_z;
    logic [CB:0]     block_y;
    logic [CB:0]     block_x;
  } location_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ptbl_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  int errors = 0;
  longint cycles = 0;
  bit sink_calm = 1'b0;

  always #5 clk_i = ~clk_i;

  point_to_block_location i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  class location_scoreboard;
    logic signed [31:0] org [3];
    logic [12:0] size [3];
    logic [35:0] dims;
    location_t pending [$];

    function new();
      org = '{0, 0, 0};
      size = '{13'd32, 13'd32, 13'd32};
      dims = '0;
    endfunction

    function void set_reg(input logic [ptbl_pkg::CFG_IDX_W-1:0] idx,
                          input logic [CFG_W-1:0] v);
      case (idx)
        ptbl_pkg::CFG_ORIGIN_X: org[0] = v[31:0];
        ptbl_pkg::CFG_ORIGIN_Y: org[1] = v[31:0];
        ptbl_pkg::CFG_ORIGIN_Z: org[2] = v[31:0];
        ptbl_pkg::CFG_BLOCK_WIDTH: size[0] = v[12:0];
        ptbl_pkg::CFG_BLOCK_HEIGHT: size[1] = v[12:0];
        ptbl_pkg::CFG_BLOCK_DEPTH: size[2] = v[12:0];
        ptbl_pkg::CFG_GRID_DIMS: dims = v[35:0];
        default: ;
      endcase
    endfunction

    function void note_point(input logic [IN_W-1:0] d);
      longint q [3];
      longint r [3];
      longint s, diff, dm;
      bit in_blk;
      location_t e;
      in_blk = 1'b1;
      for (int a = 0; a < 3; a++) begin
        s = size[a] == 0 ? 1 : (size[a] > 4096 ? 4096 : longint'(size[a]));
        diff = longint'($signed(d[a*32 +: 32])) - longint'(org[a]);
        q[a] = diff / s;
        r[a] = diff % s;
        if (r[a] < 0) begin
          q[a] -= 1;
          r[a] += s;
        end
        dm = longint'(dims[a*AB +: AB]);
        if (q[a] < 0 || q[a] >= dm) in_blk = 1'b0;
      end
      e.block_x = q[0][CB:0];
      e.block_y = q[1][CB:0];
      e.block_z = q[2][CB:0];
      e.local_x = r[0][AB-1:0];
      e.local_y = r[1][AB-1:0];
      e.local_z = r[2][AB-1:0];
      e.in_grid = in_blk;
      e.linear_index = '0;
      if (in_blk)
        e.linear_index = 36'(q[2] * longint'(dims[11:0]) * longint'(dims[23:12])
                             + q[1] * longint'(dims[11:0]) + q[0]);
      pending.push_back(e);
    endfunction

    task check_location(input logic [OUT_W-1:0] d);
      location_t g, e;
      g = d[$bits(location_t)-1:0];
      if (pending.size() == 0) begin
        report("unexpected beat", g.linear_index, 0);
        return;
      end
      e = pending.pop_front();
      if (g.block_x !== e.block_x) report("block_x", g.block_x, e.block_x);
      if (g.block_y !== e.block_y) report("block_y", g.block_y, e.block_y);
      if (g.block_z !== e.block_z) report("block_z", g.block_z, e.block_z);
      if (g.local_x !== e.local_x) report("local_x", g.local_x, e.local_x);
      if (g.local_y !== e.local_y) report("local_y", g.local_y, e.local_y);
      if (g.local_z !== e.local_z) report("local_z", g.local_z, e.local_z);
      if (g.in_grid !== e.in_grid) report("in_grid", g.in_grid, e.in_grid);
      if (g.linear_index !== e.linear_index)
        report("linear_index", g.linear_index, e.linear_index);
    endtask
  endclass

  location_scoreboard sb = new();

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_location(m_axis_tdata);
    m_axis_tready <= sink_calm ? 1'b1 : ($urandom_range(99) >= 6);
  end

  task automatic write_reg(input logic [ptbl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    sb.set_reg(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                            input bit calm);
    if (!calm) while ($urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_point({z, y, x});
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(4000)) - 2000);
      2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_f000} + $urandom_range(8191);
      default: return 32'($signed($urandom_range(300000)) - 100000);
    endcase
  endfunction

  function automatic logic [12:0] rand_size();
    case ($urandom_range(4))
      0: return 13'($urandom_range(8191));
      1: return 13'($urandom_range(1, 8));
      2: return 13'(4096 - $urandom_range(3));
      default: return 13'($urandom_range(1, 300));
    endcase
  endfunction

  task automatic random_config(input bit wild);
    logic [ptbl_pkg::CFG_IDX_W-1:0] org_idx [3];
    logic [ptbl_pkg::CFG_IDX_W-1:0] size_idx [3];
    org_idx = '{ptbl_pkg::CFG_ORIGIN_X, ptbl_pkg::CFG_ORIGIN_Y, ptbl_pkg::CFG_ORIGIN_Z};
    size_idx = '{ptbl_pkg::CFG_BLOCK_WIDTH, ptbl_pkg::CFG_BLOCK_HEIGHT,
                 ptbl_pkg::CFG_BLOCK_DEPTH};
    for (int a = 0; a < 3; a++) begin
      write_reg(org_idx[a], wild ? CFG_W'($urandom()) :
                CFG_W'(32'($signed($urandom_range(2000)) - 1000)));
      write_reg(size_idx[a], CFG_W'(rand_size()) | (CFG_W'($urandom()) << 13));
    end
    write_reg(ptbl_pkg::CFG_GRID_DIMS,
              $urandom_range(3) == 0 ? {$urandom(), 4'($urandom())} :
              {12'($urandom_range(64)), 12'($urandom_range(64)), 12'($urandom_range(64))});
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_point(32'd0, 32'd0, 32'd0, 1);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1);
    drain();

    write_reg(ptbl_pkg::CFG_ORIGIN_X, 36'h0_8000_0000);
    write_reg(ptbl_pkg::CFG_ORIGIN_Y, 36'h0_7fff_ffff);
    write_reg(ptbl_pkg::CFG_ORIGIN_Z, 36'hf_ffff_ff9c);
    write_reg(ptbl_pkg::CFG_BLOCK_WIDTH, 36'd0);
    write_reg(ptbl_pkg::CFG_BLOCK_HEIGHT, 36'd8191);
    write_reg(ptbl_pkg::CFG_BLOCK_DEPTH, 36'd4096);
    write_reg(ptbl_pkg::CFG_GRID_DIMS, 36'hfff_fff_fff);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ff9c, 1);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ef9c, 1);
    send_point(32'hffff_ffff, 32'h0000_0000, 32'h0000_0f9b, 1);
    send_point(32'h8000_0fff, 32'h8000_1000, 32'hffff_ef9b, 1);
    drain();

    write_reg(ptbl_pkg::CFG_ORIGIN_X, 36'd0);
    write_reg(ptbl_pkg::CFG_ORIGIN_Y, 36'd0);
    write_reg(ptbl_pkg::CFG_ORIGIN_Z, 36'd0);
    write_reg(ptbl_pkg::CFG_BLOCK_WIDTH, 36'd4);
    write_reg(ptbl_pkg::CFG_BLOCK_HEIGHT, 36'd4);
    write_reg(ptbl_pkg::CFG_BLOCK_DEPTH, 36'd4);
    write_reg(ptbl_pkg::CFG_GRID_DIMS, {12'd3, 12'd0, 12'd5});
    send_point(32'd5, 32'd2, 32'd1, 1);
    drain();
    write_reg(ptbl_pkg::CFG_GRID_DIMS, {12'd3, 12'd4, 12'd5});
    send_point(32'hffff_fffc, 32'd0, 32'd0, 1);
    send_point(32'hffff_fffb, 32'd0, 32'd0, 1);
    send_point(32'd19, 32'd15, 32'd11, 1);
    send_point(32'd20, 32'd15, 32'd11, 1);
    send_point(32'd19, 32'd16, 32'd11, 1);
    send_point(32'd19, 32'd15, 32'd12, 1);
    send_point(32'd7, 32'hffff_fff8, 32'd3, 1);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      random_config(ph % 3 == 2);
      sink_calm = (ph == 5);
      for (int i = 0; i < 75; i++) begin
        if ($urandom_range(3) == 0)
          send_point($urandom(), $urandom(), $urandom(), ph == 5);
        else
          send_point(sb.org[0] + 32'($signed($urandom_range(20000)) - 2000),
                     sb.org[1] + 32'($signed($urandom_range(20000)) - 2000),
                     ($urandom_range(7) == 0) ? rand_coord() :
                     sb.org[2] + 32'($signed($urandom_range(20000)) - 2000), ph == 5);
      end
      sink_calm = 1'b0;
      drain();
    end

    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
